// File: sv/mfmd_pkg.sv
// ----------------------------------------------------------------------------
// mfmd_pkg
// Shared constants and record types for the motor feedback multiturn decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

   localparam int COUNTS_PER_TURN = 8192;
   localparam int TURN_SHIFT      = $clog2(COUNTS_PER_TURN);
   localparam int HALF_LIMIT      = COUNTS_PER_TURN / 2 - 1;
   // 360 degrees in q10 per turn, divided by counts per turn
   localparam int DEG_SCALE       = 368640 / COUNTS_PER_TURN;

   localparam logic [1:0] BUS_FIRST  = 2'd0;
   localparam logic [1:0] BUS_SECOND = 2'd1;

   localparam logic [10:0] ID_BUS0_LO = 11'h201;
   localparam logic [10:0] ID_BUS0_HI = 11'h204;
   localparam logic [10:0] ID_BUS1_LO = 11'h205;
   localparam logic [10:0] ID_BUS1_HI = 11'h208;

   localparam logic signed [15:0] TURNS_MIN = 16'sh8000;
   localparam logic signed [15:0] TURNS_MAX = 16'sh7fff;

   typedef struct packed {
      logic        [15:0] offset;
      logic        [15:0] angle;
      logic signed [15:0] speed;
      logic signed [15:0] current;
      logic        [7:0]  temp;
      logic signed [15:0] turns;
   } record_type;

   typedef struct packed {
      logic               hit;
      logic        [2:0]  motor_index;
      logic        [15:0] raw_angle;
      logic signed [15:0] speed;
      logic signed [15:0] current;
      logic        [7:0]  temp;
   } frame_type;

   typedef struct packed {
      logic       en;
      logic [2:0] motor_index;
      record_type rec;
   } write_type;

   typedef struct packed {
      logic       hit;
      logic       first;
      logic [2:0] motor_index;
      record_type rec;
   } stage_type;

endpackage

// File: sv/mfmd_if.sv
// ----------------------------------------------------------------------------
// mfmd_if
// Valid/ready channels for received frames and decoded motor records.
// ----------------------------------------------------------------------------
interface mfmd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  bus_select;
   logic [10:0] frame_id;
   logic [31:0] data_high;
   logic [31:0] data_low;

   modport source (output valid, output bus_select, output frame_id,
                   output data_high, output data_low, input ready);
   modport sink   (input valid, input bus_select, input frame_id,
                   input data_high, input data_low, output ready);
endinterface

interface mfmd_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               first_frame;
   logic        [2:0]  motor_index;
   logic        [15:0] rotor_angle;
   logic signed [15:0] rotor_speed;
   logic signed [15:0] phase_current;
   logic        [7:0]  temperature;
   logic signed [15:0] turn_count;
   logic signed [29:0] unwrapped_angle;
   logic signed [34:0] total_degrees_q10;

   modport source (output valid, output accepted, output first_frame,
                   output motor_index, output rotor_angle, output rotor_speed,
                   output phase_current, output temperature, output turn_count,
                   output unwrapped_angle, output total_degrees_q10, input ready);
   modport sink   (input valid, input accepted, input first_frame,
                   input motor_index, input rotor_angle, input rotor_speed,
                   input phase_current, input temperature, input turn_count,
                   input unwrapped_angle, input total_degrees_q10, output ready);
endinterface

// File: sv/mfmd_store.sv
// ----------------------------------------------------------------------------
// mfmd_store
// Per-motor record memory with registered read, plus seen flags.
// ----------------------------------------------------------------------------
module mfmd_store #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [ADDR_W-1:0]    rd_addr,
   input  logic [ADDR_W-1:0]    seen_addr,
   input  mfmd_pkg::write_type  wr,
   output mfmd_pkg::record_type rd_data,
   output logic                 seen
);
   import mfmd_pkg::*;

   record_type              record_mem [DEPTH];
   record_type              rd_data_ff;
   logic       [DEPTH-1:0]  seen_ff;
   logic       [DEPTH-1:0]  seen_in;
   logic       [ADDR_W-1:0] wr_addr;

   assign wr_addr = wr.motor_index[ADDR_W-1:0];

   always_comb begin
      seen_in = seen_ff;
      if (advance && wr.en) begin
         seen_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // read returns the old word when the same entry is written this cycle
   always_ff @(posedge clock) begin
      if (advance) begin
         if (wr.en) begin
            record_mem[wr_addr] <= wr.rec;
         end
         rd_data_ff <= record_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign seen    = seen_ff[seen_addr];

endmodule

// File: sv/mfmd_update.sv
// ----------------------------------------------------------------------------
// mfmd_update
// Read-modify-write stage: offset capture, record update and turn tracking.
// ----------------------------------------------------------------------------
module mfmd_update #(
   parameter int ADDR_W = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 s0_valid,
   input  mfmd_pkg::frame_type  s0_frame,
   input  mfmd_pkg::record_type rd_data,
   input  logic                 seen,
   output logic [ADDR_W-1:0]    seen_addr,
   output mfmd_pkg::write_type  wr,
   output logic                 s2_valid,
   output mfmd_pkg::stage_type  s2_stage
);
   import mfmd_pkg::*;

   localparam logic signed [16:0] HALF_POS = 17'(HALF_LIMIT);
   localparam logic signed [16:0] HALF_NEG = -17'(HALF_LIMIT);

   logic               s1_valid_ff;
   frame_type          s1_frame_ff;
   write_type          fwd_ff;
   logic               s2_valid_ff;
   stage_type          s2_stage_ff;

   logic               fwd_hit;
   record_type         base;
   logic               first;
   logic signed [16:0] delta;
   logic signed [15:0] turns_in;
   record_type         rec_in;
   stage_type          s2_stage_in;

   assign seen_addr = s1_frame_ff.motor_index[ADDR_W-1:0];

   // the previous word's write lands in the same cycle as this word's read
   assign fwd_hit = fwd_ff.en && (fwd_ff.motor_index == s1_frame_ff.motor_index);
   assign base    = fwd_hit ? fwd_ff.rec : rd_data;
   assign first   = !seen;
   assign delta   = $signed({1'b0, s1_frame_ff.raw_angle}) - $signed({1'b0, base.angle});

   always_comb begin
      turns_in = base.turns;
      if (delta > HALF_POS) begin
         if (base.turns != TURNS_MIN) begin
            turns_in = base.turns - 16'sd1;
         end
      end else if (delta < HALF_NEG) begin
         if (base.turns != TURNS_MAX) begin
            turns_in = base.turns + 16'sd1;
         end
      end
   end

   always_comb begin
      rec_in       = '0;
      rec_in.angle = s1_frame_ff.raw_angle;
      if (first) begin
         rec_in.offset = s1_frame_ff.raw_angle;
      end else begin
         rec_in.offset  = base.offset;
         rec_in.speed   = s1_frame_ff.speed;
         rec_in.current = s1_frame_ff.current;
         rec_in.temp    = s1_frame_ff.temp;
         rec_in.turns   = turns_in;
      end
   end

   always_comb begin
      wr.en          = s1_valid_ff && s1_frame_ff.hit;
      wr.motor_index = s1_frame_ff.motor_index;
      wr.rec         = rec_in;
   end

   // ignored frames report an all-zero word
   always_comb begin
      s2_stage_in = '0;
      if (s1_frame_ff.hit) begin
         s2_stage_in.hit         = 1'b1;
         s2_stage_in.first       = first;
         s2_stage_in.motor_index = s1_frame_ff.motor_index;
         s2_stage_in.rec         = rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fwd_ff.en   <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid;
         s2_valid_ff <= s1_valid_ff;
         fwd_ff      <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_frame_ff <= s0_frame;
         s2_stage_ff <= s2_stage_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_stage = s2_stage_ff;

`ifndef NO_ASSERTIONS
   a_fwd_seen: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_frame_ff.hit && fwd_hit) |-> seen)
      else $error("forwarded entry not marked seen");

   a_turn_step: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_frame_ff.hit && !first) |->
         (turns_in == base.turns || turns_in == base.turns + 16'sd1 ||
          turns_in == base.turns - 16'sd1))
      else $error("turn count moved by more than one");

   a_first_offset: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_stage_ff.first) |->
         (s2_stage_ff.rec.offset == s2_stage_ff.rec.angle && s2_stage_ff.rec.turns == 16'sd0))
      else $error("first frame did not capture offset");
`endif

endmodule

// File: sv/mfmd_angle.sv
// ----------------------------------------------------------------------------
// mfmd_angle
// Total angle, degree scaling and the output register of the result channel.
// ----------------------------------------------------------------------------
module mfmd_angle (
   input  logic                clock,
   input  logic                reset,
   input  logic                s2_valid,
   input  mfmd_pkg::stage_type s2_stage,
   output logic                advance,
   mfmd_rsp_if.source          rsp_chan
);
   import mfmd_pkg::*;

   localparam logic signed [34:0] DEG_SCALE_W = 35'(DEG_SCALE);

   logic               s3_valid_ff;
   stage_type          s3_stage_ff;
   logic signed [29:0] s3_total_ff;
   logic               out_valid_ff;
   stage_type          out_stage_ff;
   logic signed [29:0] out_total_ff;
   logic signed [34:0] out_deg_ff;

   logic signed [29:0] total_in;
   logic signed [34:0] deg_in;

   assign advance = !out_valid_ff || rsp_chan.ready;

   assign total_in = ($signed(30'($signed(s2_stage.rec.turns))) <<< TURN_SHIFT)
                   + $signed(30'(s2_stage.rec.angle))
                   - $signed(30'(s2_stage.rec.offset));

   assign deg_in = $signed(35'(s3_total_ff)) * DEG_SCALE_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff  <= s2_valid;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_stage_ff  <= s2_stage;
         s3_total_ff  <= total_in;
         out_stage_ff <= s3_stage_ff;
         out_total_ff <= s3_total_ff;
         out_deg_ff   <= deg_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.accepted          = out_stage_ff.hit;
   assign rsp_chan.first_frame       = out_stage_ff.first;
   assign rsp_chan.motor_index       = out_stage_ff.motor_index;
   assign rsp_chan.rotor_angle       = out_stage_ff.rec.angle;
   assign rsp_chan.rotor_speed       = out_stage_ff.rec.speed;
   assign rsp_chan.phase_current     = out_stage_ff.rec.current;
   assign rsp_chan.temperature       = out_stage_ff.rec.temp;
   assign rsp_chan.turn_count        = out_stage_ff.rec.turns;
   assign rsp_chan.unwrapped_angle   = out_total_ff;
   assign rsp_chan.total_degrees_q10 = out_deg_ff;

`ifndef NO_ASSERTIONS
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stage_ff.first) |->
         (out_total_ff == 30'sd0 && out_deg_ff == 35'sd0))
      else $error("first frame reported nonzero total angle");
`endif

endmodule

// File: sv/motor_feedback_multiturn_decoder_unit.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder_unit
// Pipeline: registers s1, s2, s3 and out; one frame per cycle unless the
// result channel stalls. The per-motor record memory is read per frame and
// written back per matched frame; an index match forwards the prior write.
// Reset: clears stage valids and seen flags; memory content needs no reset.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder_unit #(
   parameter int MOTOR_COUNT = 8
) (
   input  logic       clock,
   input  logic       reset,
   mfmd_req_if.sink   req_chan,
   mfmd_rsp_if.source rsp_chan
);
   import mfmd_pkg::*;

   localparam int         ADDR_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam logic [3:0] MOTOR_LIMIT = 4'(MOTOR_COUNT);

   logic              advance;
   logic              s0_valid;
   logic              id_match;
   logic [2:0]        id_offset;
   logic              hit;
   frame_type         s0_frame;
   record_type        rd_data;
   logic              seen;
   logic [ADDR_W-1:0] seen_addr;
   write_type         wr;
   logic              s2_valid;
   stage_type         s2_stage;

   assign id_offset = 3'(req_chan.frame_id - ID_BUS0_LO);

   always_comb begin
      unique case (req_chan.bus_select)
         BUS_FIRST: begin
            id_match = (req_chan.frame_id >= ID_BUS0_LO) && (req_chan.frame_id <= ID_BUS0_HI);
         end
         BUS_SECOND: begin
            id_match = (req_chan.frame_id >= ID_BUS1_LO) && (req_chan.frame_id <= ID_BUS1_HI);
         end
         default: begin
            id_match = 1'b0;
         end
      endcase
   end

   assign hit = id_match && ({1'b0, id_offset} < MOTOR_LIMIT);

   always_comb begin
      s0_frame.hit         = hit;
      s0_frame.motor_index = hit ? id_offset : 3'd0;
      s0_frame.raw_angle   = req_chan.data_high[31:16];
      s0_frame.speed       = $signed(req_chan.data_high[15:0]);
      s0_frame.current     = $signed(req_chan.data_low[31:16]);
      s0_frame.temp        = req_chan.data_low[15:8];
   end

   assign req_chan.ready = advance;
   assign s0_valid       = req_chan.valid && advance;

   mfmd_store #(
      .DEPTH  (MOTOR_COUNT),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rd_addr   (s0_frame.motor_index[ADDR_W-1:0]),
      .seen_addr (seen_addr),
      .wr        (wr),
      .rd_data   (rd_data),
      .seen      (seen)
   );

   mfmd_update #(
      .ADDR_W (ADDR_W)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .s0_valid  (s0_valid),
      .s0_frame  (s0_frame),
      .rd_data   (rd_data),
      .seen      (seen),
      .seen_addr (seen_addr),
      .wr        (wr),
      .s2_valid  (s2_valid),
      .s2_stage  (s2_stage)
   );

   mfmd_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .s2_valid (s2_valid),
      .s2_stage (s2_stage),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule
